### rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define TBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off while reset is asserted
`define TBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbd_pkg
// Types and framing constants for the typed block deframer.
// ---------------------------------------------------------------------------
package tbd_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hc6;
  localparam logic [7:0] TYPE_CMD  = 8'h87;
  localparam logic [7:0] TYPE_DATA = 8'he1;
  localparam logic [7:0] TRL_BYTE  = 8'h6c;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_BUSY    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_DONE    = 3'd2,
    EV_BADHDR  = 3'd3,
    EV_BADTYPE = 3'd4,
    EV_BADTRL  = 3'd5,
    EV_TIMEOUT = 3'd6
  } event_t;

  typedef struct packed {
    phase_t      phase;
    logic        is_cmd;
    logic [15:0] decl_len;
    logic [15:0] remaining;
  } frame_state_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic        is_cmd;
    logic [15:0] length;
    logic        last;
  } frame_result_t;

endpackage

### rtl/typed_block_deframer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// typed_block_deframer_core
// Parses header/type/length/payload/trailer blocks from a byte stream and
// gives one result per received byte or timeout transaction.
// ---------------------------------------------------------------------------
// Input channel (in_*): one transaction per received byte, or a line
// timeout / link error when in_action is 1.
// Result channel (out_*): exactly one transaction per input transaction, in
// order: progress, payload byte, block done or an error code.
// The result shows on out_* in the cycle after its input is taken.
// Throughput: one byte per cycle unless a stalled result holds the input;
// the parse step is a single pass through the frame state update between
// the state registers and the result register.
// A stalled result is held in the result register; in_stall rises only
// while a result is held and out_stall is high, so no transaction is lost.
// Reset (rst_n low, synchronous) returns the parser to awaiting a header,
// clears type and length, and empties the result register.
// ---------------------------------------------------------------------------
module typed_block_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_command,
  output logic [15:0] out_block_length,
  output logic        out_last_payload
);

  tbd_pkg::frame_state_t  state_r;
  tbd_pkg::frame_state_t  state_nxt;
  tbd_pkg::frame_result_t res_r;
  tbd_pkg::frame_result_t res_nxt;
  logic                   out_valid_r;
  logic                   in_take;

  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  tbd_step u_step (
    .cur     (state_r),
    .action  (in_action),
    .rx_byte (in_rx_byte),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= tbd_pkg::PH_HEADER;
      state_r.is_cmd    <= 1'b0;
      state_r.decl_len  <= 16'd0;
      state_r.remaining <= 16'd0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_take) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = res_r.ev;
  assign out_payload_byte = res_r.data;
  assign out_is_command   = res_r.is_cmd;
  assign out_block_length = res_r.length;
  assign out_last_payload = res_r.last;

endmodule

### rtl/tbd_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbd_step
// One byte of frame parsing: next state and result from current state.
// ---------------------------------------------------------------------------
module tbd_step (
  input  tbd_pkg::frame_state_t  cur,
  input  logic                   action,
  input  logic [7:0]             rx_byte,
  output tbd_pkg::frame_state_t  nxt,
  output tbd_pkg::frame_result_t res
);

  logic [15:0] full_len;
  logic [15:0] rem_dec;

  assign full_len = {cur.decl_len[15:8], rx_byte};
  assign rem_dec  = (cur.remaining != 16'd0) ? (cur.remaining - 16'd1) : cur.remaining;

  always_comb begin
    nxt      = cur;
    res.ev   = tbd_pkg::EV_BUSY;
    res.data = 8'd0;
    res.last = 1'b0;
    if (action) begin
      res.ev    = tbd_pkg::EV_TIMEOUT;
      nxt.phase = tbd_pkg::PH_HEADER;
    end else begin
      case (cur.phase)
        tbd_pkg::PH_TYPE: begin
          if (rx_byte == tbd_pkg::TYPE_CMD) begin
            nxt.is_cmd = 1'b1;
            nxt.phase  = tbd_pkg::PH_LEN_HI;
          end else if (rx_byte == tbd_pkg::TYPE_DATA) begin
            nxt.is_cmd = 1'b0;
            nxt.phase  = tbd_pkg::PH_LEN_HI;
          end else begin
            res.ev    = tbd_pkg::EV_BADTYPE;
            res.data  = rx_byte;
            nxt.phase = tbd_pkg::PH_HEADER;
          end
        end
        tbd_pkg::PH_LEN_HI: begin
          nxt.decl_len = {rx_byte, 8'd0};
          nxt.phase    = tbd_pkg::PH_LEN_LO;
        end
        tbd_pkg::PH_LEN_LO: begin
          nxt.decl_len  = full_len;
          nxt.remaining = full_len;
          // empty block skips straight to the trailer
          nxt.phase     = (full_len == 16'd0) ? tbd_pkg::PH_TRAILER : tbd_pkg::PH_PAYLOAD;
        end
        tbd_pkg::PH_PAYLOAD: begin
          res.ev        = tbd_pkg::EV_PAYLOAD;
          res.data      = rx_byte;
          res.last      = (cur.remaining <= 16'd1);
          nxt.remaining = rem_dec;
          if (rem_dec == 16'd0) begin
            nxt.phase = tbd_pkg::PH_TRAILER;
          end
        end
        tbd_pkg::PH_TRAILER: begin
          if (rx_byte == tbd_pkg::TRL_BYTE) begin
            res.ev = tbd_pkg::EV_DONE;
          end else begin
            res.ev   = tbd_pkg::EV_BADTRL;
            res.data = rx_byte;
          end
          nxt.phase = tbd_pkg::PH_HEADER;
        end
        default: begin
          // header phase, and any phase code with no meaning
          if (rx_byte == tbd_pkg::HDR_BYTE) begin
            nxt.phase = tbd_pkg::PH_TYPE;
          end else begin
            res.ev    = tbd_pkg::EV_BADHDR;
            res.data  = rx_byte;
            nxt.phase = tbd_pkg::PH_HEADER;
          end
        end
      endcase
    end
    res.is_cmd = nxt.is_cmd;
    res.length = nxt.decl_len;
  end

endmodule

### rtl/tbd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbd_checker
// Port-level checks on the deframer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_res,
  input logic [7:0]  out_payload_byte,
  input logic        out_is_command,
  input logic [15:0] out_block_length,
  input logic        out_last_payload
);

  logic [28:0] out_bundle;
  logic        in_take;
  logic        out_is_timeout;
  logic        out_is_payload;
  logic        no_byte_ev;

  assign out_bundle     = {out_event_res, out_payload_byte, out_is_command, out_block_length,
                           out_last_payload};
  assign in_take        = in_valid && !in_stall;
  assign out_is_timeout = (out_event_res == tbd_pkg::EV_TIMEOUT);
  assign out_is_payload = (out_event_res == tbd_pkg::EV_PAYLOAD);
  assign no_byte_ev     = (out_event_res == tbd_pkg::EV_BUSY) ||
                          (out_event_res == tbd_pkg::EV_DONE) ||
                          (out_event_res == tbd_pkg::EV_TIMEOUT);

  // held result keeps its payload while stalled
  `TBD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bundle))

  // input backs up only behind a held, stalled result
  `TBD_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)

  // a timeout transaction always reports a timeout event
  `TBD_ASSERT_NXT(a_timeout, clk, rst_n, in_take && in_action, out_valid && out_is_timeout)

  // last flag only on payload events
  `TBD_ASSERT_IMP(a_last, clk, rst_n, out_valid && out_last_payload, out_is_payload)

  // events without a byte carry zero
  `TBD_ASSERT_IMP(a_zero_data, clk, rst_n, out_valid && no_byte_ev, out_payload_byte == 8'd0)

endmodule

bind typed_block_deframer_core tbd_checker u_tbd_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for typed_block_deframer_core. A short table of byte
// transactions covers the field extremes, each error code and timeouts in
// mid-block; then random blocks, noise and broken blocks follow. Every
// result is compared against its table entry or a block parser kept in the
// bench, under bursty input traffic and a randomly stalling receiver.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int NUM_ROWS       = 26;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  typedef struct packed {
    logic                   act;
    logic [7:0]             rx;
    logic                   fixed;
    tbd_pkg::frame_result_t res;
  } stim_row_t;

  localparam tbd_pkg::frame_result_t FROM_PARSER = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_event_res;
  logic [7:0]  out_payload_byte;
  logic        out_is_command;
  logic [15:0] out_block_length;
  logic        out_last_payload;

  typed_block_deframer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_is_command   (out_is_command),
    .out_block_length (out_block_length),
    .out_last_payload (out_last_payload)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // parser state mirrored in the bench
  tbd_pkg::phase_t fr_phase = tbd_pkg::PH_HEADER;
  logic            fr_cmd   = 1'b0;
  logic [15:0]     fr_len   = '0;
  logic [15:0]     fr_left  = '0;

  tbd_pkg::frame_result_t expected_results [$];
  int                     mismatch_count = 0;
  int                     idle_cycles    = 0;
  int                     sent_count     = 0;
  int                     burst_left     = 0;
  bit                     hold_req       = 1'b0;
  bit                     hold_done      = 1'b0;

  // typed expectation riding along with the transaction on offer
  logic                   cur_fixed;
  tbd_pkg::frame_result_t cur_fixed_res;

  stim_row_t dir_rows [0:NUM_ROWS-1] = '{
    '{1'b0, 8'h00, 1'b1, '{tbd_pkg::EV_BADHDR,  8'h00, 1'b0, 16'h0000, 1'b0}},
    '{1'b0, 8'hff, 1'b1, '{tbd_pkg::EV_BADHDR,  8'hff, 1'b0, 16'h0000, 1'b0}},
    '{1'b1, 8'hff, 1'b1, '{tbd_pkg::EV_TIMEOUT, 8'h00, 1'b0, 16'h0000, 1'b0}},
    '{1'b0, 8'hc6, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b0, 16'h0000, 1'b0}},
    '{1'b0, 8'h87, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b1, 16'h0000, 1'b0}},
    '{1'b0, 8'hff, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b1, 16'hff00, 1'b0}},
    '{1'b0, 8'hff, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b1, 16'hffff, 1'b0}},
    '{1'b0, 8'h00, 1'b1, '{tbd_pkg::EV_PAYLOAD, 8'h00, 1'b1, 16'hffff, 1'b0}},
    '{1'b0, 8'hff, 1'b1, '{tbd_pkg::EV_PAYLOAD, 8'hff, 1'b1, 16'hffff, 1'b0}},
    // timeout in the middle of a payload keeps type and length
    '{1'b1, 8'h00, 1'b1, '{tbd_pkg::EV_TIMEOUT, 8'h00, 1'b1, 16'hffff, 1'b0}},
    '{1'b0, 8'hc6, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b1, 16'hffff, 1'b0}},
    '{1'b0, 8'h55, 1'b1, '{tbd_pkg::EV_BADTYPE, 8'h55, 1'b1, 16'hffff, 1'b0}},
    '{1'b0, 8'hc6, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b1, 16'hffff, 1'b0}},
    '{1'b0, 8'he1, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b0, 16'hffff, 1'b0}},
    // zero length goes straight to the trailer
    '{1'b0, 8'h00, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b0, 16'h0000, 1'b0}},
    '{1'b0, 8'h00, 1'b1, '{tbd_pkg::EV_BUSY,    8'h00, 1'b0, 16'h0000, 1'b0}},
    '{1'b0, 8'h6c, 1'b1, '{tbd_pkg::EV_DONE,    8'h00, 1'b0, 16'h0000, 1'b0}},
    '{1'b0, 8'hc6, 1'b0, FROM_PARSER},
    '{1'b0, 8'h87, 1'b0, FROM_PARSER},
    '{1'b0, 8'h00, 1'b0, FROM_PARSER},
    '{1'b0, 8'h02, 1'b0, FROM_PARSER},
    '{1'b0, 8'h5a, 1'b0, FROM_PARSER},
    '{1'b0, 8'ha5, 1'b1, '{tbd_pkg::EV_PAYLOAD, 8'ha5, 1'b1, 16'h0002, 1'b1}},
    '{1'b0, 8'h3c, 1'b1, '{tbd_pkg::EV_BADTRL,  8'h3c, 1'b1, 16'h0002, 1'b0}},
    '{1'b0, 8'hc6, 1'b0, FROM_PARSER},
    '{1'b1, 8'ha5, 1'b1, '{tbd_pkg::EV_TIMEOUT, 8'h00, 1'b1, 16'h0002, 1'b0}}
  };

  function automatic tbd_pkg::frame_result_t parse_byte(input logic act,
                                                        input logic [7:0] b);
    tbd_pkg::frame_result_t r;
    r    = '0;
    r.ev = tbd_pkg::EV_BUSY;
    if (act) begin
      r.ev     = tbd_pkg::EV_TIMEOUT;
      fr_phase = tbd_pkg::PH_HEADER;
    end else begin
      case (fr_phase)
        tbd_pkg::PH_TYPE: begin
          if (b == tbd_pkg::TYPE_CMD) begin
            fr_cmd   = 1'b1;
            fr_phase = tbd_pkg::PH_LEN_HI;
          end else if (b == tbd_pkg::TYPE_DATA) begin
            fr_cmd   = 1'b0;
            fr_phase = tbd_pkg::PH_LEN_HI;
          end else begin
            r.ev     = tbd_pkg::EV_BADTYPE;
            r.data   = b;
            fr_phase = tbd_pkg::PH_HEADER;
          end
        end
        tbd_pkg::PH_LEN_HI: begin
          fr_len   = {b, 8'h00};
          fr_phase = tbd_pkg::PH_LEN_LO;
        end
        tbd_pkg::PH_LEN_LO: begin
          fr_len   = {fr_len[15:8], b};
          fr_left  = fr_len;
          fr_phase = (fr_left == 16'd0) ? tbd_pkg::PH_TRAILER : tbd_pkg::PH_PAYLOAD;
        end
        tbd_pkg::PH_PAYLOAD: begin
          r.ev   = tbd_pkg::EV_PAYLOAD;
          r.data = b;
          r.last = (fr_left <= 16'd1);
          if (fr_left != 16'd0) fr_left = fr_left - 16'd1;
          if (fr_left == 16'd0) fr_phase = tbd_pkg::PH_TRAILER;
        end
        tbd_pkg::PH_TRAILER: begin
          if (b == tbd_pkg::TRL_BYTE) begin
            r.ev = tbd_pkg::EV_DONE;
          end else begin
            r.ev   = tbd_pkg::EV_BADTRL;
            r.data = b;
          end
          fr_phase = tbd_pkg::PH_HEADER;
        end
        default: begin
          if (b == tbd_pkg::HDR_BYTE) begin
            fr_phase = tbd_pkg::PH_TYPE;
          end else begin
            r.ev     = tbd_pkg::EV_BADHDR;
            r.data   = b;
            fr_phase = tbd_pkg::PH_HEADER;
          end
        end
      endcase
    end
    r.is_cmd = fr_cmd;
    r.length = fr_len;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // input and result monitor, scoreboard and watchdog
  always @(posedge clk) begin
    tbd_pkg::frame_result_t pred;
    tbd_pkg::frame_result_t want;
    bit                     moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        pred  = parse_byte(in_action, in_rx_byte);
        expected_results.push_back(cur_fixed ? cur_fixed_res : pred);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, got event %0d byte %h",
                   $time, out_event_res, out_payload_byte);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", 16'(want.ev), 16'(out_event_res));
          check_field("payload_byte", 16'(want.data), 16'(out_payload_byte));
          check_field("is_command", 16'(want.is_cmd), 16'(out_is_command));
          check_field("block_length", want.length, out_block_length);
          check_field("last_payload", 16'(want.last), 16'(out_last_payload));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("typed_block_deframer_core test failed");
      $finish;
    end
  end

  // offer one transaction, with a random gap first when a burst has run out
  task automatic offer(input logic act, input logic [7:0] b, input logic fixed,
                       input tbd_pkg::frame_result_t fixed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_rx_byte    <= b;
    cur_fixed     <= fixed;
    cur_fixed_res <= fixed_res;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    offer(1'b0, b, 1'b0, FROM_PARSER);
  endtask

  task automatic send_timeout();
    offer(1'b1, 8'($urandom), 1'b0, FROM_PARSER);
  endtask

  // one block with random content; sometimes cut short by a timeout or
  // closed with a wrong trailer
  task automatic send_block();
    int unsigned len;
    int unsigned pick;
    int unsigned cut;
    int unsigned k;
    logic [7:0]  kind;
    pick = $urandom_range(0, 99);
    if (pick < 75)      len = $urandom_range(0, 6);
    else if (pick < 95) len = $urandom_range(7, 48);
    else                len = $urandom_range(0, 65535);
    kind = $urandom_range(0, 1) ? tbd_pkg::TYPE_CMD : tbd_pkg::TYPE_DATA;
    cut  = 0;
    if (len > 300) cut = $urandom_range(4, 40);
    else if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, len + 4);
    for (k = 0; k < len + 5; k++) begin
      if (cut != 0 && k == cut) begin
        send_timeout();
        return;
      end
      if (k == 0)            send_rx(tbd_pkg::HDR_BYTE);
      else if (k == 1)       send_rx(kind);
      else if (k == 2)       send_rx(len[15:8]);
      else if (k == 3)       send_rx(len[7:0]);
      else if (k < len + 4)  send_rx(8'($urandom));
      else if ($urandom_range(0, 9) != 0) send_rx(tbd_pkg::TRL_BYTE);
      else                   send_rx(8'($urandom));
    end
  endtask

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned run;
    int unsigned per;
    int unsigned k;
    out_stall = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 80);
      per  = $urandom_range(2, 5);
      for (k = 0; k < run; k++) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= $urandom_range(0, 1);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (k % per == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = 1'b0;
    in_rx_byte    = 8'h00;
    cur_fixed     = 1'b0;
    cur_fixed_res = FROM_PARSER;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      offer(dir_rows[i].act, dir_rows[i].rx, dir_rows[i].fixed, dir_rows[i].res);
    end

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count > 400) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_block();
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        repeat (n) offer($urandom_range(0, 15) == 0, 8'($urandom), 1'b0, FROM_PARSER);
      end else begin
        // header followed by a byte that is most likely not a type
        send_rx(tbd_pkg::HDR_BYTE);
        send_rx(8'($urandom));
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("typed_block_deframer_core test passed");
    end else begin
      $display("typed_block_deframer_core test failed");
    end
    $finish;
  end

endmodule
